@@ src/integer_property_classifier_core_macros.svh @@
// assertion helpers shared by the classifier rtl
`ifndef INTEGER_PROPERTY_CLASSIFIER_CORE_MACROS_SVH
`define INTEGER_PROPERTY_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IPC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define IPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipc assertion failed");

`endif

@@ src/ipc_pkg.sv @@
`default_nettype none

package ipc_pkg;

    // default width of the classified value
    localparam int VALUE_WIDTH_DEF = 31;

    // trial division constants
    localparam int EVEN_PRIME      = 2;
    localparam int FIRST_ODD_DIV   = 3;
    localparam int DIV_STEP        = 2;

    // status of the shared remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

`default_nettype wire

@@ src/ipc_rem_unit.sv @@
`default_nettype none
`include "integer_property_classifier_core_macros.svh"

// bit-serial restoring remainder, one dividend bit per cycle
module ipc_rem_unit
    import ipc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DIV_WIDTH   = (VALUE_WIDTH_DEF + 1) / 2 + 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [DIV_WIDTH-1:0]   divisor,
    output rem_status_t                 status
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DIV_WIDTH-1:0]   dvs_reg, dvs_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH:0]     diff;
    logic                   fits;

    // one restoring step: bring in the next dividend bit and try a subtract
    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

    `IPC_ASSERT_IMPLY(a_start_when_free, aclk, aresetn, start, !busy_reg && divisor != '0)
    `IPC_ASSERT_NEXT(a_start_goes_busy, aclk, aresetn, start, busy_reg && !done_reg)
    `IPC_ASSERT_NEXT(a_last_step_done, aclk, aresetn, busy_reg && !start && cnt_reg == '0,
        done_reg && !busy_reg)

endmodule

`default_nettype wire

@@ src/integer_property_classifier_core.sv @@
// channel  | ports                                         | direction
// ---------+-----------------------------------------------+----------
// input    | s_valid, s_ready, s_value                     | in
// result   | m_valid, m_ready, m_is_even, m_is_prime,      | out
//          | m_is_square                                   |
//
// one value is taken at a time; s_ready is high only while the sequencer is idle
// the square root is found first, digit by digit, then each odd trial divisor up to
// the root is tried in turn in the bit-serial remainder unit
// worst case at 31 bits (a large prime) is about 23170 divisions
// the result sits in an output register, so a new value is taken while it waits
// reset is synchronous active low and clears the sequencer and result valid
`default_nettype none
`include "integer_property_classifier_core_macros.svh"

module integer_property_classifier_core
    import ipc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_is_even,
    output logic                        m_is_prime,
    output logic                        m_is_square
);

    localparam int RW = (VALUE_WIDTH + 1) / 2;
    localparam int SW = 2 * RW;
    localparam int DW = RW + 1;
    localparam int QW = $clog2(RW);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQRT   = 3'd1;
    localparam logic [2:0] ST_PRE    = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [SW-1:0]          shift_reg, shift_next;
    logic [RW+1:0]          srem_reg, srem_next;
    logic [RW-1:0]          root_reg, root_next;
    logic [QW-1:0]          qcnt_reg, qcnt_next;
    logic [DW-1:0]          d_reg, d_next;
    logic                   prime_reg, prime_next;
    logic                   square_reg, square_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   even_out_reg, even_out_next;
    logic                   prime_out_reg, prime_out_next;
    logic                   square_out_reg, square_out_next;

    logic [RW+1:0]          cand;
    logic [RW+1:0]          sq_trial;
    logic                   sq_fits;
    logic                   div_start;
    rem_status_t            div_status;

    // digit-by-digit square root step: two value bits in, one root bit out
    assign cand     = {srem_reg[RW-1:0], shift_reg[SW-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_fits  = cand >= sq_trial;

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        value_next      = value_reg;
        shift_next      = shift_reg;
        srem_next       = srem_reg;
        root_next       = root_reg;
        qcnt_next       = qcnt_reg;
        d_next          = d_reg;
        prime_next      = prime_reg;
        square_next     = square_reg;
        m_valid_next    = m_valid_reg;
        even_out_next   = even_out_reg;
        prime_out_next  = prime_out_reg;
        square_out_next = square_out_reg;
        div_start       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = s_value;
                    shift_next = SW'(s_value);
                    srem_next  = '0;
                    root_next  = '0;
                    qcnt_next  = QW'(RW - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                srem_next  = sq_fits ? (cand - sq_trial) : cand;
                root_next  = {root_reg[RW-2:0], sq_fits};
                shift_next = {shift_reg[SW-3:0], 2'b00};
                if (qcnt_reg == '0) begin
                    state_next = ST_PRE;
                end else begin
                    qcnt_next = qcnt_reg - 1'b1;
                end
            end
            ST_PRE: begin
                square_next = (srem_reg == '0);
                d_next      = DW'(FIRST_ODD_DIV);
                // zero, one and even values settle without division
                if (value_reg[VALUE_WIDTH-1:1] == '0) begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end else if (value_reg == VALUE_WIDTH'(EVEN_PRIME)) begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end else if (!value_reg[0]) begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (d_reg > {1'b0, root_reg}) begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_status.done) begin
                    if (div_status.zero) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        d_next     = d_reg + DW'(DIV_STEP);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                // load the output register once the previous result is gone
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    even_out_next   = !value_reg[0];
                    prime_out_next  = prime_reg;
                    square_out_next = square_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        value_reg      <= value_next;
        shift_reg      <= shift_next;
        srem_reg       <= srem_next;
        root_reg       <= root_next;
        qcnt_reg       <= qcnt_next;
        d_reg          <= d_next;
        prime_reg      <= prime_next;
        square_reg     <= square_next;
        even_out_reg   <= even_out_next;
        prime_out_reg  <= prime_out_next;
        square_out_reg <= square_out_next;
    end

    // shared remainder unit for trial division
    ipc_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (value_reg),
        .divisor  (d_reg),
        .status   (div_status)
    );

    assign m_valid     = m_valid_reg;
    assign m_is_even   = even_out_reg;
    assign m_is_prime  = prime_out_reg;
    assign m_is_square = square_out_reg;

    `IPC_ASSERT_IMPLY(a_prime_not_square, aclk, aresetn, m_valid_reg,
        !(prime_out_reg && square_out_reg))
    `IPC_ASSERT_IMPLY(a_odd_divisor, aclk, aresetn, div_start, d_reg[0] && value_reg[0])
    `IPC_ASSERT_IMPLY(a_done_only_waiting, aclk, aresetn, div_status.done,
        state_reg == ST_WAIT)

endmodule

`default_nettype wire

@@ tb/sv/integer_property_classifier_core_checker.sv @@
`default_nettype none

module integer_property_classifier_core_checker
    import ipc_pkg::*;
#(
    parameter int VW = VALUE_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_ready,
    input  wire logic [VW-1:0] s_value,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    input  wire logic          m_is_even,
    input  wire logic          m_is_prime,
    input  wire logic          m_is_square,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 prime_count,
    output int                 square_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic is_even;
        logic is_prime;
        logic is_square;
    } class_flags_t;

    class_flags_t flags_due[$];

    // exact integer square root, digit by digit
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem = n;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // trial division by odd divisors up to the root
    function automatic logic trial_divide(input longint unsigned n, input longint unsigned root);
        longint unsigned d;
        if (n < EVEN_PRIME)
            return 1'b0;
        if (n == EVEN_PRIME)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 64'(FIRST_ODD_DIV); d <= root; d += 64'(DIV_STEP)) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic class_flags_t classify(input logic [VW-1:0] v);
        class_flags_t f;
        longint unsigned n;
        longint unsigned root;
        n = 64'(v);
        root = int_sqrt(n);
        f.is_even = ~v[0];
        f.is_prime = trial_divide(n, root);
        f.is_square = (root * root == n);
        return f;
    endfunction

    initial begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        prime_count = 0;
        square_count = 0;
    end

    // predict on input transfer, compare on result transfer
    always @(posedge aclk) begin
        class_flags_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                flags_due.push_back(classify(s_value));
            if (m_valid && m_ready) begin
                if (flags_due.size() == 0) begin
                    $error("result transfer with no value outstanding");
                    fail_count = fail_count + 1;
                end else begin
                    want = flags_due.pop_front();
                    result_count = result_count + 1;
                    if (want.is_prime)
                        prime_count = prime_count + 1;
                    if (want.is_square)
                        square_count = square_count + 1;
                    if (m_is_even !== want.is_even) begin
                        $error("is_even: expected %0b, got %0b", want.is_even, m_is_even);
                        fail_count = fail_count + 1;
                    end
                    if (m_is_prime !== want.is_prime) begin
                        $error("is_prime: expected %0b, got %0b", want.is_prime, m_is_prime);
                        fail_count = fail_count + 1;
                    end
                    if (m_is_square !== want.is_square) begin
                        $error("is_square: expected %0b, got %0b", want.is_square,
                               m_is_square);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_count = flags_due.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/integer_property_classifier_core_tb.sv @@
`default_nettype none

module integer_property_classifier_core_tb;
    import ipc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int N_RANDOM    = 70;
    localparam int LONG_HOLD   = 3000;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_WAIT  = 200;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [VW-1:0] s_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_is_even;
    logic          m_is_prime;
    logic          m_is_square;

    int fail_count;
    int pending_count;
    int result_count;
    int prime_count;
    int square_count;

    int cycle_count = 0;
    bit hold_req = 1'b0;
    int burst_left = 1;
    bit steady = 1'b0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    integer_property_classifier_core #(
        .VALUE_WIDTH(VW)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_is_even(m_is_even),
        .m_is_prime(m_is_prime),
        .m_is_square(m_is_square)
    );

    integer_property_classifier_core_checker #(
        .VW(VW)
    ) checker_inst (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_is_even(m_is_even),
        .m_is_prime(m_is_prime),
        .m_is_square(m_is_square),
        .fail_count(fail_count),
        .pending_count(pending_count),
        .result_count(result_count),
        .prime_count(prime_count),
        .square_count(square_count)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[integer_property_classifier_core] ERROR");
            $finish;
        end
    end

    // result side: stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
                repeat (span) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(negedge aclk);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    // one transfer on the input side, called at a falling edge
    task automatic send_value(input logic [VW-1:0] v);
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // send inside the current burst, then maybe a gap
    task automatic offer(input logic [VW-1:0] v);
        send_value(v);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            steady = ($urandom_range(0, 3) == 0);
            idle_for(steady ? 0 : $urandom_range(0, 30));
        end
    endtask

    task automatic wait_drained();
        idle_for(1);
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // mostly small values so trial division stays short; wide ones carry a small factor
    function automatic logic [VW-1:0] pick_value();
        int unsigned sel;
        int unsigned root;
        logic [VW-1:0] wide;
        sel = $urandom_range(0, 99);
        wide = VW'($urandom);
        if (sel < 45)
            return VW'($urandom_range(0, 4095));
        else if (sel < 70) begin
            root = $urandom_range(0, 2047);
            return VW'(root * root);
        end else if (sel < 85)
            return VW'($urandom_range(0, 20'hFFFFF));
        else if (sel < 93)
            return {wide[VW-1:1], 1'b0};
        else
            return VW'((wide / 3) * 3);
    endfunction

    logic [VW-1:0] directed_values[] = '{
        0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 91, 97, 121, 1024,
        65535, 65536, 65537,
        31'd1073741823, 31'd1073741824, 31'd2147395600,
        31'd2147483645, 31'd2147483646, 31'h7FFF_FFFF
    };

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corner values, including the largest field value, a prime
        foreach (directed_values[i])
            offer(directed_values[i]);
        wait_drained();

        // long hold-off on the result side while values keep coming
        hold_req = 1'b1;
        repeat (6)
            send_value(VW'($urandom_range(0, 1023)));
        idle_for(1);

        // random part, with one full drain midway
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2)
                wait_drained();
            offer(pick_value());
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("classified %0d values: %0d prime, %0d perfect square", result_count,
                 prime_count, square_count);
        $display("covered corner values, bursty input, result stalls and a %0d-cycle hold-off",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("[integer_property_classifier_core] OK");
        else
            $display("[integer_property_classifier_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
